/* sv/rtgs_pkg.sv */
`timescale 1ns / 1ps

package rtgs_pkg;

  // Smoothed rpm word and divide-by-ten reciprocal (floor(d/10) = (d*M)>>27 for d < 2^26)
  localparam int            SMOOTH_W    = 24;
  localparam int            DIV10_SHIFT = 27;
  localparam logic [23:0]   DIV10_MUL   = 24'hCCCCCD;
  localparam int            PROD_W      = 48;

  // Gear ratio: ratio_first + up to seven steps of 16 bits
  localparam int            RATIO_W     = 19;
  localparam int            SPEED_W     = 43;
  localparam logic [3:0]    GEAR_MIN    = 4'd1;
  localparam logic [3:0]    GEAR_MAX    = 4'd8;

  localparam int            CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHIFT_THRESHOLD = 3'd0,
    CFG_HOLDOFF_MS      = 3'd1,
    CFG_LOWEST_GEAR     = 3'd2,
    CFG_HIGHEST_GEAR    = 3'd3,
    CFG_RATIO_FIRST     = 3'd4,
    CFG_RATIO_STEP      = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SHIFT_NONE = 2'd0,
    SHIFT_DOWN = 2'd1,
    SHIFT_UP   = 2'd2
  } shift_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SMOOTH,
    ST_NEWER,
    ST_DECIDE,
    ST_SPEED,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [13:0] threshold;
    logic [15:0] holdoff;
    logic [3:0]  gear_lo;
    logic [3:0]  gear_hi;
    logic [15:0] ratio_first;
    logic [15:0] ratio_step;
  } cfg_t;

  typedef struct packed {
    logic [SMOOTH_W-1:0] goal;
    logic [31:0]         now_ms;
  } q_item_t;

  // Clamp a gear limit into one to eight
  function automatic logic [3:0] clamp_gear(input logic [3:0] g);
    logic [3:0] res;
    res = g;
    if (g < GEAR_MIN) res = GEAR_MIN;
    if (g > GEAR_MAX) res = GEAR_MAX;
    return res;
  endfunction

endpackage

/* sv/rtgs_ram.sv */
`timescale 1ns / 1ps

module rtgs_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ra_en,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic                     rb_en,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] ra_data_r;
  logic [WIDTH-1:0] rb_data_r;

  // Write one word, read two registered
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (ra_en) ra_data_r <= mem_r[ra_addr];
    if (rb_en) rb_data_r <= mem_r[rb_addr];
  end

  assign ra_data = ra_data_r;
  assign rb_data = rb_data_r;

endmodule

/* sv/rtgs_front.sv */
`timescale 1ns / 1ps

module rtgs_front #(
  parameter int RPM_BITS = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [13:0]       in_rpm_target,
  input  logic [31:0]       in_now_ms,
  output logic              q_valid,
  input  logic              q_pop,
  output rtgs_pkg::q_item_t q_item
);

  localparam int FRAC = rtgs_pkg::SMOOTH_W - RPM_BITS;
  localparam logic [rtgs_pkg::SMOOTH_W-1:0] RPM_MAX =
    rtgs_pkg::SMOOTH_W'((1 << RPM_BITS) - 1);

  rtgs_pkg::q_item_t item;
  rtgs_pkg::q_item_t slot_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;
  logic [1:0]        count_nxt;
  logic [rtgs_pkg::SMOOTH_W-1:0] tgt;
  logic              push;
  logic              pop;

  // Saturate the target and move it to the fixed-point grid
  always_comb begin
    tgt = rtgs_pkg::SMOOTH_W'(in_rpm_target);
    if (tgt > RPM_MAX) tgt = RPM_MAX;
    item.goal   = tgt << FRAC;
    item.now_ms = in_now_ms;
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    if (!push && pop) count_nxt = count_r - 2'd1;
  end

  // Two-entry queue toward the back end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wr_ptr_r] <= item;
        wr_ptr_r         <= !wr_ptr_r;
      end
      if (pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

/* sv/rtgs_back.sv */
`timescale 1ns / 1ps

module rtgs_back #(
  parameter int WINDOW   = 64,
  parameter int RPM_BITS = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rtgs_pkg::cfg_t    cfg,
  input  logic              q_valid,
  output logic              q_pop,
  input  rtgs_pkg::q_item_t q_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [13:0]       out_smoothed_rpm,
  output logic [3:0]        out_gear_now,
  output logic [15:0]       out_road_speed,
  output logic [1:0]        out_shift_code
);

  localparam int SW_S  = rtgs_pkg::SMOOTH_W;
  localparam int HALF  = WINDOW / 2;
  localparam int OFS_C = WINDOW - HALF;
  localparam int AW    = $clog2(WINDOW);
  localparam int FW    = $clog2(WINDOW + 1);
  localparam int FRAC  = SW_S - RPM_BITS;
  localparam int SW    = RPM_BITS + $clog2(HALF + 1);
  localparam int LW    = 14 + $clog2(HALF + 1);
  localparam int CW    = (SW > LW) ? SW : LW;
  localparam int RW    = rtgs_pkg::RATIO_W;
  localparam int PW    = rtgs_pkg::SPEED_W;

  rtgs_pkg::state_t      state_r;
  rtgs_pkg::state_t      state_nxt;
  rtgs_pkg::shift_code_t code_r;
  rtgs_pkg::shift_code_t code_out_r;

  logic [AW-1:0]     head_r;
  logic [FW-1:0]     fill_r;
  logic [SW_S-1:0]   smooth_r;
  logic [SW-1:0]     older_r;
  logic [SW-1:0]     newer_r;
  logic [3:0]        gear_r;
  logic [31:0]       last_shift_r;

  logic [31:0]       now_r;
  logic [SW_S-1:0]   diff_r;
  logic              up_dir_r;
  logic [rtgs_pkg::PROD_W-1:0] prod_r;
  logic              va_r;
  logic              vb_r;
  logic              vc_r;
  logic [RPM_BITS-1:0] passing_r;
  logic              late_r;
  logic [LW-1:0]     limit_r;
  logic [RW-1:0]     ratio_cur_r;
  logic [RW-1:0]     ratio_sel_r;
  logic [PW-1:0]     prod2_r;

  logic              out_valid_r;
  logic [13:0]       smoothed_r;
  logic [3:0]        gear_out_r;
  logic [15:0]       speed_r;

  logic [AW:0]       sum_b;
  logic [AW:0]       sum_c;
  logic [AW-1:0]     slot_b;
  logic [AW-1:0]     slot_c;
  logic              full;
  logic              valid_a;
  logic              valid_b;
  logic              valid_c;
  logic [SW_S-1:0]   sample_w;
  logic [SW_S-1:0]   tenth;
  logic [PW-1:0]     spd_full;
  logic [CW-1:0]     od;
  logic [CW-1:0]     nw;
  logic [CW-1:0]     lim;
  logic              dn_cond;
  logic              up_cond;

  logic                ra_en;
  logic                rb_en;
  logic [AW-1:0]       ra_addr;
  logic                we;
  logic [RPM_BITS-1:0] rda;
  logic [RPM_BITS-1:0] rdb;
  logic                out_load;

  // Slots of the half boundaries relative to the oldest entry
  always_comb begin
    sum_b  = {1'b0, head_r} + (AW + 1)'(HALF);
    sum_c  = {1'b0, head_r} + (AW + 1)'(OFS_C);
    slot_b = (sum_b >= (AW + 1)'(WINDOW)) ? AW'(sum_b - (AW + 1)'(WINDOW)) : sum_b[AW-1:0];
    slot_c = (sum_c >= (AW + 1)'(WINDOW)) ? AW'(sum_c - (AW + 1)'(WINDOW)) : sum_c[AW-1:0];
  end

  // Slots not yet written since reset read as zero
  assign full    = (fill_r == FW'(WINDOW));
  assign valid_a = full || (FW'(head_r) < fill_r);
  assign valid_b = full || (FW'(slot_b) < fill_r);
  assign valid_c = full || (FW'(slot_c) < fill_r);

  assign sample_w = smooth_r >> FRAC;
  assign tenth    = SW_S'(prod_r >> rtgs_pkg::DIV10_SHIFT);
  assign spd_full = prod2_r >> (FRAC + 16);

  assign od      = CW'(older_r);
  assign nw      = CW'(newer_r);
  assign lim     = CW'(limit_r);
  assign dn_cond = (od > nw) && ((od - nw) > lim);
  assign up_cond = (nw > od) && ((nw - od) > lim);

  rtgs_ram #(
    .WIDTH (RPM_BITS),
    .DEPTH (WINDOW)
  ) u_window (
    .clk     (clk),
    .we      (we),
    .waddr   (head_r),
    .wdata   (sample_w[RPM_BITS-1:0]),
    .ra_en   (ra_en),
    .ra_addr (ra_addr),
    .ra_data (rda),
    .rb_en   (rb_en),
    .rb_addr (slot_b),
    .rb_data (rdb)
  );

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rtgs_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Step through one item: read, smooth, window, decide, speed, deliver
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    ra_en     = 1'b0;
    rb_en     = 1'b0;
    ra_addr   = head_r;
    we        = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      rtgs_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          ra_en     = 1'b1;
          rb_en     = 1'b1;
          state_nxt = rtgs_pkg::ST_READ;
        end
      end
      rtgs_pkg::ST_READ: begin
        ra_en     = 1'b1;
        ra_addr   = slot_c;
        state_nxt = rtgs_pkg::ST_SMOOTH;
      end
      rtgs_pkg::ST_SMOOTH: state_nxt = rtgs_pkg::ST_NEWER;
      rtgs_pkg::ST_NEWER: begin
        we        = 1'b1;
        state_nxt = rtgs_pkg::ST_DECIDE;
      end
      rtgs_pkg::ST_DECIDE: state_nxt = rtgs_pkg::ST_SPEED;
      rtgs_pkg::ST_SPEED:  state_nxt = rtgs_pkg::ST_OUT;
      rtgs_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = rtgs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rtgs_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      fill_r       <= '0;
      smooth_r     <= '0;
      older_r      <= '0;
      newer_r      <= '0;
      gear_r       <= rtgs_pkg::GEAR_MIN;
      last_shift_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // drop a taken beat, load a new one
      out_valid_r <= out_load || (out_valid_r && !out_ready);

      case (state_r)
        rtgs_pkg::ST_IDLE: begin
          if (q_valid) begin
            now_r <= q_item.now_ms;
            if (q_item.goal >= smooth_r) begin
              up_dir_r <= 1'b1;
              diff_r   <= q_item.goal - smooth_r;
            end else begin
              up_dir_r <= 1'b0;
              diff_r   <= smooth_r - q_item.goal;
            end
            va_r <= valid_a;
            vb_r <= valid_b;
            vc_r <= valid_c;
          end
        end
        rtgs_pkg::ST_READ: begin
          older_r     <= older_r + SW'(vb_r ? rdb : '0) - SW'(va_r ? rda : '0);
          prod_r      <= rtgs_pkg::PROD_W'(diff_r) * rtgs_pkg::PROD_W'(rtgs_pkg::DIV10_MUL);
          late_r      <= (now_r - last_shift_r) > 32'(cfg.holdoff);
          limit_r     <= LW'(cfg.threshold) * LW'(HALF);
          ratio_cur_r <= RW'(cfg.ratio_first) + RW'(gear_r - 4'd1) * RW'(cfg.ratio_step);
        end
        rtgs_pkg::ST_SMOOTH: begin
          passing_r <= vc_r ? rda : '0;
          smooth_r  <= up_dir_r ? (smooth_r + tenth) : (smooth_r - tenth);
        end
        rtgs_pkg::ST_NEWER: begin
          newer_r <= newer_r + SW'(sample_w[RPM_BITS-1:0]) - SW'(passing_r);
          head_r  <= (head_r == AW'(WINDOW - 1)) ? '0 : head_r + AW'(1);
          if (!full) fill_r <= fill_r + FW'(1);
        end
        rtgs_pkg::ST_DECIDE: begin
          if (dn_cond && late_r && (gear_r > cfg.gear_lo)) begin
            gear_r       <= gear_r - 4'd1;
            last_shift_r <= now_r;
            code_r       <= rtgs_pkg::SHIFT_DOWN;
            ratio_sel_r  <= ratio_cur_r - RW'(cfg.ratio_step);
          end else if (up_cond && late_r && (gear_r < cfg.gear_hi)) begin
            gear_r       <= gear_r + 4'd1;
            last_shift_r <= now_r;
            code_r       <= rtgs_pkg::SHIFT_UP;
            ratio_sel_r  <= ratio_cur_r + RW'(cfg.ratio_step);
          end else begin
            code_r       <= rtgs_pkg::SHIFT_NONE;
            ratio_sel_r  <= ratio_cur_r;
          end
        end
        rtgs_pkg::ST_SPEED: begin
          prod2_r <= PW'(smooth_r) * PW'(ratio_sel_r);
        end
        rtgs_pkg::ST_OUT: begin
          if (out_load) begin
            smoothed_r <= sample_w[13:0];
            gear_out_r <= gear_r;
            speed_r    <= (spd_full > PW'(16'hFFFF)) ? 16'hFFFF : spd_full[15:0];
            code_out_r <= code_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_smoothed_rpm = smoothed_r;
  assign out_gear_now     = gear_out_r;
  assign out_road_speed   = speed_r;
  assign out_shift_code   = code_out_r;

endmodule

/* sv/rpm_trend_gear_selector_top.sv */
`timescale 1ns / 1ps
// From the accepting edge an item passes the states READ, SMOOTH, NEWER, DECIDE,
// SPEED and OUT before out_valid rises; the back-end sequencer takes one item at a time
// (window reads on the RAM ports, divide-by-ten multiply, gear decision, speed multiply).
// Input queue of two lets up to two items wait while an item is in work.
// Reset: synchronous, active low; registers return to defaults, window reads as zero
// through a fill count, so no clearing pass is needed.
module rpm_trend_gear_selector_top #(
  parameter int WINDOW   = 64,
  parameter int RPM_BITS = 14
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [13:0]                    in_rpm_target,
  input  logic [31:0]                    in_now_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [13:0]                    out_smoothed_rpm,
  output logic [3:0]                     out_gear_now,
  output logic [15:0]                    out_road_speed,
  output logic [1:0]                     out_shift_code,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rtgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);

  logic [13:0] threshold_r;
  logic [15:0] holdoff_r;
  logic [3:0]  lowest_r;
  logic [3:0]  highest_r;
  logic [15:0] ratio_first_r;
  logic [15:0] ratio_step_r;

  rtgs_pkg::cfg_t    cfg;
  rtgs_pkg::q_item_t q_item;
  logic              q_valid;
  logic              q_pop;

  assign cfg_ready = 1'b1;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= 14'd30;
      holdoff_r     <= 16'd1000;
      lowest_r      <= 4'd1;
      highest_r     <= 4'd6;
      ratio_first_r <= 16'd393;
      ratio_step_r  <= 16'd328;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rtgs_pkg::CFG_SHIFT_THRESHOLD: threshold_r   <= cfg_data[13:0];
        rtgs_pkg::CFG_HOLDOFF_MS:      holdoff_r     <= cfg_data;
        rtgs_pkg::CFG_LOWEST_GEAR:     lowest_r      <= cfg_data[3:0];
        rtgs_pkg::CFG_HIGHEST_GEAR:    highest_r     <= cfg_data[3:0];
        rtgs_pkg::CFG_RATIO_FIRST:     ratio_first_r <= cfg_data;
        rtgs_pkg::CFG_RATIO_STEP:      ratio_step_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp gear limits before use
  always_comb begin
    cfg.threshold   = threshold_r;
    cfg.holdoff     = holdoff_r;
    cfg.gear_lo     = rtgs_pkg::clamp_gear(lowest_r);
    cfg.gear_hi     = rtgs_pkg::clamp_gear(highest_r);
    cfg.ratio_first = ratio_first_r;
    cfg.ratio_step  = ratio_step_r;
  end

  rtgs_front #(
    .RPM_BITS (RPM_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rpm_target (in_rpm_target),
    .in_now_ms     (in_now_ms),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item)
  );

  rtgs_back #(
    .WINDOW   (WINDOW),
    .RPM_BITS (RPM_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_item           (q_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_smoothed_rpm (out_smoothed_rpm),
    .out_gear_now     (out_gear_now),
    .out_road_speed   (out_road_speed),
    .out_shift_code   (out_shift_code)
  );

endmodule

/* sv/rtgs_checker.sv */
`timescale 1ns / 1ps

module rtgs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] out_smoothed_rpm,
  input logic [3:0]  out_gear_now,
  input logic [15:0] out_road_speed,
  input logic [1:0]  out_shift_code
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_smoothed_rpm)
      && $stable(out_gear_now) && $stable(out_road_speed) && $stable(out_shift_code))
    else $error("result beat changed while stalled");

  // Gear stays within one to eight
  a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gear_now >= 4'd1) && (out_gear_now <= 4'd8))
    else $error("gear out of range");

  // An up shift lands on gear two or higher, a down shift on seven or lower
  a_shift_gear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_shift_code != rtgs_pkg::SHIFT_UP) || (out_gear_now >= 4'd2))
      && ((out_shift_code != rtgs_pkg::SHIFT_DOWN) || (out_gear_now <= 4'd7)))
    else $error("shift code does not match gear");

  // Reset empties the result stage
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rpm_trend_gear_selector_top rtgs_checker u_rtgs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_smoothed_rpm (out_smoothed_rpm),
  .out_gear_now     (out_gear_now),
  .out_road_speed   (out_road_speed),
  .out_shift_code   (out_shift_code)
);
